FILE: sv/rpb64_pkg.sv
// ----------------------------------------------------------------------------
// rpb64_pkg
// Types, constants and the character table shared by the record packing
// base64url encoder.
// ----------------------------------------------------------------------------
package rpb64_pkg;

    localparam logic [23:0] TS_MAX = 24'hFFFFFF;
    localparam int          Q_DEPTH = 2;

    localparam logic [1:0] CARRY_NONE = 2'd0;
    localparam logic [1:0] CARRY_ONE  = 2'd1;
    localparam logic [1:0] CARRY_TWO  = 2'd2;

    localparam logic [2:0] LAST_IDX_GROUP     = 3'd3;
    localparam logic [2:0] LAST_IDX_FLUSH_ONE = 3'd5;
    localparam logic [2:0] LAST_IDX_FLUSH_TWO = 3'd6;
    localparam logic [2:0] LAST_IDX_TWO_GROUP = 3'd7;

    typedef struct packed {
        logic [47:0] bytes;
        logic [2:0]  last_idx;
        logic        last;
    } t_job;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] count;
    } t_q_stat;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'd65 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'd71 + {1'b0, v};
        end else if (v < 6'd62) begin
            c = {1'b0, v} - 7'd4;
        end else if (v == 6'd62) begin
            c = 7'd45;
        end else begin
            c = 7'd95;
        end
        return c;
    endfunction

endpackage

FILE: sv/rpb64_if.sv
// ----------------------------------------------------------------------------
// rpb64 channel interfaces
// Valid/ready channels for input records and encoded characters.
// ----------------------------------------------------------------------------
interface rpb64_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  checkpoint;
    logic [31:0] timestamp;
    logic        last_record;

    modport source (output valid, output checkpoint, output timestamp,
                    output last_record, input ready);
    modport sink   (input valid, input checkpoint, input timestamp,
                    input last_record, output ready);
endinterface

interface rpb64_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);
endinterface

FILE: sv/rpb64_front.sv
// ----------------------------------------------------------------------------
// rpb64_front
// Accepts records, saturates the timestamp, merges the leftover bytes and
// queues a job of up to six bytes with the index of its last character.
// ----------------------------------------------------------------------------
module rpb64_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpb64_in_if.sink             i_in,
    input  rpb64_pkg::t_q_stat   i_q_stat,
    output logic                 o_push,
    output rpb64_pkg::t_job      o_job
);

    logic [15:0] r_carry_bytes;
    logic [1:0]  r_carry_count;
    logic [15:0] n_carry_bytes;
    logic [1:0]  n_carry_count;
    logic [23:0] w_ts;
    logic [31:0] w_rec;

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    always_comb begin
        w_ts  = (|i_in.timestamp[31:24]) ? rpb64_pkg::TS_MAX : i_in.timestamp[23:0];
        w_rec = {i_in.checkpoint, w_ts};
        o_job.last = i_in.last_record;
        case (r_carry_count)
            rpb64_pkg::CARRY_ONE: begin
                o_job.bytes    = {r_carry_bytes[7:0], w_rec, 8'h00};
                o_job.last_idx = i_in.last_record ? rpb64_pkg::LAST_IDX_FLUSH_TWO
                                                  : rpb64_pkg::LAST_IDX_GROUP;
                n_carry_bytes  = i_in.last_record ? 16'h0000 : w_rec[15:0];
                n_carry_count  = i_in.last_record ? rpb64_pkg::CARRY_NONE
                                                  : rpb64_pkg::CARRY_TWO;
            end
            rpb64_pkg::CARRY_TWO: begin
                o_job.bytes    = {r_carry_bytes, w_rec};
                o_job.last_idx = rpb64_pkg::LAST_IDX_TWO_GROUP;
                n_carry_bytes  = 16'h0000;
                n_carry_count  = rpb64_pkg::CARRY_NONE;
            end
            default: begin
                o_job.bytes    = {w_rec, 16'h0000};
                o_job.last_idx = i_in.last_record ? rpb64_pkg::LAST_IDX_FLUSH_ONE
                                                  : rpb64_pkg::LAST_IDX_GROUP;
                n_carry_bytes  = i_in.last_record ? 16'h0000 : {8'h00, w_rec[7:0]};
                n_carry_count  = i_in.last_record ? rpb64_pkg::CARRY_NONE
                                                  : rpb64_pkg::CARRY_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry_bytes <= 16'h0000;
            r_carry_count <= rpb64_pkg::CARRY_NONE;
        end else if (o_push) begin
            r_carry_bytes <= n_carry_bytes;
            r_carry_count <= n_carry_count;
        end
    end

endmodule

FILE: sv/rpb64_queue.sv
// ----------------------------------------------------------------------------
// rpb64_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module rpb64_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rpb64_pkg::t_job      i_job,
    input  logic                 i_pop,
    output rpb64_pkg::t_job      o_head,
    output rpb64_pkg::t_q_stat   o_stat
);

    rpb64_pkg::t_job r_mem [rpb64_pkg::Q_DEPTH];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.full  = (r_count == 2'(rpb64_pkg::Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: sv/rpb64_back.sv
// ----------------------------------------------------------------------------
// rpb64_back
// Walks the sextets of the head job, one character per beat, into the
// output register.
// ----------------------------------------------------------------------------
module rpb64_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rpb64_pkg::t_job      i_head,
    input  rpb64_pkg::t_q_stat   i_q_stat,
    output logic                 o_pop,
    rpb64_out_if.source          o_out
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_final;
    logic       w_load;
    logic       w_take;
    logic       w_end;
    logic [5:0] w_hi;
    logic [5:0] w_sextet;

    always_comb begin
        w_load   = !r_valid || o_out.ready;
        w_take   = w_load && !i_q_stat.empty;
        w_end    = (r_idx == i_head.last_idx);
        o_pop    = w_take && w_end;
        w_hi     = 6'd47 - (6'(r_idx) * 6'd6);
        w_sextet = i_head.bytes[w_hi -: 6];
    end

    assign o_out.valid      = r_valid;
    assign o_out.character  = r_char;
    assign o_out.final_char = r_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (w_take) begin
            r_valid <= 1'b1;
            r_idx   <= w_end ? 3'd0 : r_idx + 3'd1;
        end else if (w_load) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_char  <= rpb64_pkg::sextet_char(w_sextet);
            r_final <= i_head.last && w_end;
        end
    end

endmodule

FILE: sv/record_pack_base64url_encoder_unit.sv
// A record is written into the job queue; its first character then goes into the output register.
// One character per cycle while the output is ready; a job yields 4, 6, 7 or 8 characters.
// A two-entry job queue lets records enter while earlier characters are still emitted.
// Reset clears the leftover bytes, empties the queue and clears the output valid and sextet index.
// ----------------------------------------------------------------------------
// record_pack_base64url_encoder_unit
// Packs checkpoint/timestamp records into bytes and emits unpadded base64url.
// ----------------------------------------------------------------------------
module record_pack_base64url_encoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rpb64_in_if.sink      i_in,
    rpb64_out_if.source   o_out
);

    rpb64_pkg::t_job    w_job;
    rpb64_pkg::t_job    w_head;
    rpb64_pkg::t_q_stat w_q_stat;
    logic               w_push;
    logic               w_pop;

    rpb64_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    rpb64_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    rpb64_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.count != 2'd3)
        else $error("job queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job popped from empty queue");

    a_pop_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.empty && !w_push) |=> !w_pop)
        else $error("pop without any queued job");
`endif

endmodule
